// ===== rtl/cbha_pkg.sv =====
// Shared constants and types for the contiguous bank heap allocator.
package cbha_pkg;

  // Heap geometry. BANK_BYTES must be a power of two.
  localparam int unsigned NUM_BANKS  = 128;
  localparam int unsigned BANK_BYTES = 64;
  localparam int unsigned HEAP_BASE  = 46848;

  localparam int unsigned BANK_SHIFT  = $clog2(BANK_BYTES);
  localparam int unsigned IDX_W       = $clog2(NUM_BANKS);
  localparam int unsigned CNT_W       = $clog2(NUM_BANKS + 1);
  localparam int unsigned SIZE_W      = 32;
  localparam int unsigned NEED_FULL_W = SIZE_W + 1 - BANK_SHIFT;
  localparam int unsigned RES_ADDR_W  = 16;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [SIZE_W-1:0] HEAP_BASE_W  = SIZE_W'(HEAP_BASE);
  localparam logic [SIZE_W-1:0] HEAP_BYTES_W = SIZE_W'(NUM_BANKS * BANK_BYTES);
  localparam logic [SIZE_W-1:0] ADDR_LIMIT_W = SIZE_W'(32'hFFFF);
  localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(NUM_BANKS - 1);

  // Request opcodes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOC_FAIL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL_FREE = 2'd2;

  // One entry of the bank table.
  typedef struct packed {
    logic             used;
    logic             head;
    logic [IDX_W-1:0] following;
  } bank_entry_t;

  localparam int unsigned ENTRY_W = $bits(bank_entry_t);

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } bank_rd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    bank_entry_t      data;
  } bank_wr_t;

endpackage

// ===== rtl/cbha_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module cbha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/cbha_bank_store.sv =====
// Bank table: RAM plus per-entry valid bits so the table reads as all free after reset.
module cbha_bank_store
  import cbha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  bank_rd_t    rd_req,
  input  bank_wr_t    wr_req,
  output bank_entry_t rd_entry
);

  logic [NUM_BANKS-1:0] vld_r;
  logic                 rd_vld_r;
  logic [ENTRY_W-1:0]   ram_q;

  cbha_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BANKS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_req.en),
    .wr_addr (wr_req.addr),
    .wr_data (wr_req.data),
    .rd_en   (rd_req.en),
    .rd_addr (rd_req.addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_req.en) begin
        vld_r[wr_req.addr] <= 1'b1;
      end
      if (rd_req.en) begin
        rd_vld_r <= vld_r[rd_req.addr];
      end
    end
  end

  // An entry never written since reset reads as a free bank.
  assign rd_entry = rd_vld_r ? bank_entry_t'(ram_q) : '0;

endmodule

// ===== rtl/contiguous_bank_heap_allocator_core.sv =====
// First-fit allocator over a heap of fixed-size banks, with the bank table held in one
// synchronous RAM. An allocate reads the table one bank per cycle from bank 0 until it
// finds a long enough free run, then writes the run one bank per cycle and loads the
// result register. Zero, oversize and failed requests finish after the check, the scan
// or the base address check. A free reads the head entry of the run, then clears the
// run's banks in turn up to its last bank; a rejected free address finishes after the
// address check. One request is in flight at a time; a new request is taken once the
// previous result sits in the output register, which holds it until the transfer on
// the result side.
module contiguous_bank_heap_allocator_core
  import cbha_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [SIZE_W-1:0]     in_alloc_size,
  input  logic [SIZE_W-1:0]     in_free_address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RES_ADDR_W-1:0] out_result_address,
  output logic [STATUS_W-1:0]   out_status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_BASE,
    S_PLACE,
    S_FREE_CHK,
    S_CLEAR,
    S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        need_r, need_nxt;
  logic [CNT_W-1:0]        run_r, run_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [IDX_W-1:0]        start_r, start_nxt;
  logic [IDX_W-1:0]        wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]        fol_r, fol_nxt;
  logic                    head_r, head_nxt;
  logic [IDX_W-1:0]        last_r, last_nxt;
  logic [RES_ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic [STATUS_W-1:0]     res_status_r, res_status_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [RES_ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;

  bank_rd_t    rd_req;
  bank_wr_t    wr_req;
  bank_entry_t rd_entry;

  logic [SIZE_W:0]        size_sum;
  logic [NEED_FULL_W-1:0] need_full;
  logic [SIZE_W-1:0]      free_off;
  logic                   free_legal;
  logic [IDX_W-1:0]       free_idx;
  logic [CNT_W-1:0]       run_inc;
  logic [CNT_W-1:0]       start_wide;
  logic [SIZE_W-1:0]      base_calc;
  logic [IDX_W:0]         last_sum;

  cbha_bank_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_req   (rd_req),
    .wr_req   (wr_req),
    .rd_entry (rd_entry)
  );

  // Request decode.
  assign size_sum   = {1'b0, in_alloc_size} + (SIZE_W + 1)'(BANK_BYTES - 1);
  assign need_full  = size_sum[SIZE_W:BANK_SHIFT];
  assign free_off   = in_free_address - HEAP_BASE_W;
  assign free_legal = (in_free_address >= HEAP_BASE_W) && (free_off < HEAP_BYTES_W) &&
                      (free_off[BANK_SHIFT-1:0] == '0);
  assign free_idx   = free_off[BANK_SHIFT +: IDX_W];

  assign run_inc    = rd_entry.used ? '0 : run_r + CNT_W'(1);
  assign start_wide = CNT_W'(idx_r) + CNT_W'(1) - need_r;
  assign base_calc  = HEAP_BASE_W + (SIZE_W'(start_r) << BANK_SHIFT);
  assign last_sum   = (IDX_W + 1)'(idx_r) + (IDX_W + 1)'(rd_entry.following);

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    need_nxt       = need_r;
    run_nxt        = run_r;
    idx_nxt        = idx_r;
    start_nxt      = start_r;
    wr_idx_nxt     = wr_idx_r;
    fol_nxt        = fol_r;
    head_nxt       = head_r;
    last_nxt       = last_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    rd_req         = '0;
    wr_req         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_addr_nxt = '0;
          if (in_op == OP_FREE) begin
            if (free_legal) begin
              rd_req.en   = 1'b1;
              rd_req.addr = free_idx;
              idx_nxt     = free_idx;
              state_nxt   = S_FREE_CHK;
            end else begin
              res_status_nxt = ST_ILLEGAL_FREE;
              state_nxt      = S_DONE;
            end
          end else begin
            if ((in_alloc_size == '0) || (need_full > NEED_FULL_W'(NUM_BANKS))) begin
              res_status_nxt = ST_ALLOC_FAIL;
              state_nxt      = S_DONE;
            end else begin
              need_nxt    = need_full[CNT_W-1:0];
              run_nxt     = '0;
              idx_nxt     = '0;
              rd_req.en   = 1'b1;
              rd_req.addr = '0;
              state_nxt   = S_SCAN;
            end
          end
        end
      end

      // Entry idx_r arrives from the RAM; the read of the next bank is issued alongside.
      S_SCAN: begin
        run_nxt = run_inc;
        if (run_inc == need_r) begin
          start_nxt = start_wide[IDX_W-1:0];
          state_nxt = S_BASE;
        end else if (idx_r == LAST_IDX) begin
          res_status_nxt = ST_ALLOC_FAIL;
          state_nxt      = S_DONE;
        end else begin
          rd_req.en   = 1'b1;
          rd_req.addr = idx_r + IDX_W'(1);
          idx_nxt     = idx_r + IDX_W'(1);
        end
      end

      S_BASE: begin
        if (base_calc > ADDR_LIMIT_W) begin
          res_status_nxt = ST_ALLOC_FAIL;
          state_nxt      = S_DONE;
        end else begin
          res_addr_nxt = base_calc[RES_ADDR_W-1:0];
          wr_idx_nxt   = start_r;
          fol_nxt      = IDX_W'(need_r - CNT_W'(1));
          head_nxt     = 1'b1;
          state_nxt    = S_PLACE;
        end
      end

      S_PLACE: begin
        wr_req.en             = 1'b1;
        wr_req.addr           = wr_idx_r;
        wr_req.data.used      = 1'b1;
        wr_req.data.head      = head_r;
        wr_req.data.following = fol_r;
        head_nxt              = 1'b0;
        if (fol_r == '0) begin
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
        end else begin
          wr_idx_nxt = wr_idx_r + IDX_W'(1);
          fol_nxt    = fol_r - IDX_W'(1);
        end
      end

      S_FREE_CHK: begin
        if (!rd_entry.used || !rd_entry.head) begin
          res_status_nxt = ST_ILLEGAL_FREE;
          state_nxt      = S_DONE;
        end else begin
          // A trailing count that runs past the heap end stops at the last bank.
          last_nxt   = (last_sum > (IDX_W + 1)'(LAST_IDX)) ? LAST_IDX : last_sum[IDX_W-1:0];
          wr_idx_nxt = idx_r;
          state_nxt  = S_CLEAR;
        end
      end

      S_CLEAR: begin
        wr_req.en   = 1'b1;
        wr_req.addr = wr_idx_r;
        wr_req.data = '0;
        if (wr_idx_r == last_r) begin
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
        end else begin
          wr_idx_nxt = wr_idx_r + IDX_W'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    need_r       <= need_nxt;
    run_r        <= run_nxt;
    idx_r        <= idx_nxt;
    start_r      <= start_nxt;
    wr_idx_r     <= wr_idx_nxt;
    fol_r        <= fol_nxt;
    head_r       <= head_nxt;
    last_r       <= last_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_status         = out_status_r;

  // The table is written only while a run is being placed or released.
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    wr_req.en |-> (state_r == S_PLACE || state_r == S_CLEAR))
    else $error("bank table written outside place or clear");

  // The remaining trailing count never reaches the run length.
  a_place_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLACE) |-> (CNT_W'(fol_r) < need_r))
    else $error("trailing count out of range while placing");

  // A release walk never passes its last bank.
  a_clear_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (wr_idx_r <= last_r))
    else $error("release walk past its last bank");

  // A nonzero returned address is a bank-aligned address inside the heap.
  a_addr_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_addr_r != '0) |->
      (out_status_r == ST_OK && SIZE_W'(out_addr_r) >= HEAP_BASE_W &&
       ((SIZE_W'(out_addr_r) - HEAP_BASE_W) & SIZE_W'(BANK_BYTES - 1)) == '0))
    else $error("returned address outside heap or misaligned");

endmodule
